FILE: rtl/i64d_pkg.sv
package i64d_pkg;

  // Width of every operand and result field on the channels.
  localparam int FIELD_W = 64;

  // Default operand width used by the divider core.
  localparam int DATA_W_DEFAULT = 64;

  // Division mode carried in req_type.
  localparam logic REQ_UNSIGNED = 1'b0;
  localparam logic REQ_SIGNED   = 1'b1;

  typedef logic [FIELD_W-1:0] field_t;

endpackage

FILE: rtl/i64d_if.sv
interface i64d_req_if;
  import i64d_pkg::*;

  logic   valid;
  logic   ready;
  logic   req_type;
  field_t dividend;
  field_t divisor;

  modport source (output valid, output req_type, output dividend, output divisor,
                  input ready);
  modport sink   (input valid, input req_type, input dividend, input divisor,
                  output ready);
endinterface

interface i64d_rsp_if;
  import i64d_pkg::*;

  logic   valid;
  logic   ready;
  field_t quotient;
  field_t remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

FILE: rtl/int64_divider_signed_unsigned.sv
// Pipelined 64-bit integer divider, unsigned or signed two's complement, returning the
// quotient and the remainder of each request in one result beat. Only the low DATA_WIDTH
// bits of each operand are used and the result fields are zero above DATA_WIDTH. A new
// request beat can be taken in every cycle while the skid register is empty. The edge that
// accepts a request loads it into the first of DATA_WIDTH + 3 registers in a row: one
// stage takes operand magnitudes and signs, DATA_WIDTH stages each produce one quotient
// bit with a DATA_WIDTH+1 bit compare and subtract, one stage applies the signs, and one
// output register drives the result channel. A skid register behind the output lets the
// pipeline keep moving while a result waits, until the next result leaving it is parked;
// in_ready drops only while both the output and the skid register hold results.
// A zero divisor returns a zero quotient and a zero remainder in either mode. In signed
// mode the quotient is negated when the operand signs differ, the remainder takes the
// dividend's sign, and the minimum value divided by minus one wraps to the minimum value.
module int64_divider_signed_unsigned #(
  parameter int DATA_WIDTH = i64d_pkg::DATA_W_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  i64d_req_if.sink          in_req,
  i64d_rsp_if.source        out_rsp
);
  import i64d_pkg::*;

  localparam int DW = DATA_WIDTH;

  // One entry of the division pipeline. n holds the dividend bits still to be shifted
  // in, most significant first; r is the partial remainder and q the quotient so far.
  typedef struct packed {
    logic [DW-1:0] n;
    logic [DW-1:0] d;
    logic [DW-1:0] r;
    logic [DW-1:0] q;
    logic          q_neg;
    logic          r_neg;
    logic          d_zero;
  } stage_t;

  // One restoring step. The shifted remainder is kept DW+1 bits wide, so a carry out of
  // the top bit is never lost and always forces the subtraction.
  function automatic stage_t div_step(stage_t s);
    stage_t        o;
    logic [DW:0]   r_ext;
    logic [DW:0]   diff;
    logic          take;
    o     = s;
    r_ext = {s.r, s.n[DW-1]};
    diff  = r_ext - {1'b0, s.d};
    take  = (r_ext >= {1'b0, s.d});
    o.n   = s.n << 1;
    o.r   = take ? diff[DW-1:0] : r_ext[DW-1:0];
    o.q   = {s.q[DW-2:0], take};
    return o;
  endfunction

  logic          en;
  logic          in_acc;

  // Pipeline valid bits travel alongside st_r.
  logic [DW:0]   vld_r;
  stage_t        st_r [0:DW];
  stage_t        pre_nxt;

  logic          post_vld_r;
  field_t        post_q_r;
  field_t        post_rem_r;
  field_t        post_q_nxt;
  field_t        post_rem_nxt;

  logic          out_vld_r;
  field_t        out_q_r;
  field_t        out_rem_r;

  logic          skid_vld_r;
  field_t        skid_q_r;
  field_t        skid_rem_r;

  // The whole pipeline moves together; it only halts while the skid register is full.
  assign en           = !skid_vld_r;
  assign in_acc       = in_req.valid && en;
  assign in_req.ready = en;

  // Entry stage: operand magnitudes, result signs and the zero divisor flag.
  always_comb begin
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic          a_neg;
    logic          b_neg;
    logic          sgn;
    a     = in_req.dividend[DW-1:0];
    b     = in_req.divisor[DW-1:0];
    sgn   = (in_req.req_type == REQ_SIGNED);
    a_neg = sgn && a[DW-1];
    b_neg = sgn && b[DW-1];
    pre_nxt        = '0;
    pre_nxt.n      = a_neg ? (~a + 1'b1) : a;
    pre_nxt.d      = b_neg ? (~b + 1'b1) : b;
    pre_nxt.q_neg  = a_neg ^ b_neg;
    pre_nxt.r_neg  = a_neg;
    pre_nxt.d_zero = (b == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DW-1:0], in_acc};
    end
    if (en) begin
      st_r[0] <= pre_nxt;
      for (int k = 0; k < DW; k++) begin
        st_r[k+1] <= div_step(st_r[k]);
      end
    end
  end

  // Sign fix-up and zero divisor override on the finished entry.
  always_comb begin
    stage_t        s;
    logic [DW-1:0] q;
    logic [DW-1:0] rm;
    s  = st_r[DW];
    q  = s.q_neg ? (~s.q + 1'b1) : s.q;
    rm = s.r_neg ? (~s.r + 1'b1) : s.r;
    post_q_nxt   = '0;
    post_rem_nxt = '0;
    if (!s.d_zero) begin
      post_q_nxt[DW-1:0]   = q;
      post_rem_nxt[DW-1:0] = rm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_vld_r <= 1'b0;
    end else if (en) begin
      post_vld_r <= vld_r[DW];
    end
    if (en) begin
      post_q_r   <= post_q_nxt;
      post_rem_r <= post_rem_nxt;
    end
  end

  // Output register with a skid register behind it. When the output is free it loads
  // from the skid register first; otherwise a result leaving the pipeline while the
  // output is held is parked in the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_rsp.ready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= post_vld_r;
      end
    end else if (en && post_vld_r) begin
      skid_vld_r <= 1'b1;
    end
    if (out_rsp.ready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_q_r   <= skid_q_r;
        out_rem_r <= skid_rem_r;
      end else begin
        out_q_r   <= post_q_r;
        out_rem_r <= post_rem_r;
      end
    end else if (en && post_vld_r) begin
      skid_q_r   <= post_q_r;
      skid_rem_r <= post_rem_r;
    end
  end

  assign out_rsp.valid     = out_vld_r;
  assign out_rsp.quotient  = out_q_r;
  assign out_rsp.remainder = out_rem_r;

endmodule

FILE: rtl/i64d_checker.sv
module i64d_checker #(
  parameter int DATA_WIDTH = i64d_pkg::DATA_W_DEFAULT
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input i64d_pkg::field_t       quotient,
  input i64d_pkg::field_t       remainder
);
  import i64d_pkg::*;

  // Entry stage, one stage per quotient bit, sign stage, output and skid registers.
  localparam int DEPTH = DATA_WIDTH + 4;
  localparam int CNT_W = $clog2(DEPTH + 1) + 1;

  logic [CNT_W-1:0] inflight_r;
  logic [CNT_W-1:0] inflight_nxt;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // A held result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(remainder))
    else $error("result changed while stalled");

  // Back-pressure on the request side only comes from a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("request side stalled with no result waiting");

  // Once stalled, the request side stays stalled until the result is taken.
  a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready |=> !in_ready)
    else $error("request side released without a result beat");

  // Results never appear without a request and never exceed the pipeline's capacity.
  a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || inflight_r != '0) && (inflight_r <= CNT_W'(DEPTH)))
    else $error("result count out of step with requests");

endmodule

bind int64_divider_signed_unsigned i64d_checker #(.DATA_WIDTH(DATA_WIDTH)) u_i64d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .quotient  (out_rsp.quotient),
  .remainder (out_rsp.remainder)
);
